// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level core to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfb_pkg.sv =====
// Package with the types, constants and helper functions of the framebuffer core.
package lfb_pkg;

    localparam int LFB_SCREEN_WIDTH  = 480;
    localparam int LFB_SCREEN_HEIGHT = 320;

    localparam int LFB_PIXEL_W       = 24;
    localparam int LFB_COORD_W       = 12;
    localparam int LFB_ROW_HEAD      = 22;
    localparam int LFB_IN_TDATA_W    = 104;
    localparam int LFB_OUT_TDATA_W   = 16;

    // Display command bytes.
    localparam logic [7:0] CMD_COL_ADDR  = 8'h2a;
    localparam logic [7:0] CMD_ROW_ADDR  = 8'h2b;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2c;

    // Positions inside the per-row command header.
    localparam logic [4:0] HDR_PAD_COL      = 5'd0;
    localparam logic [4:0] HDR_CMD_COL      = 5'd1;
    localparam logic [4:0] HDR_COL_END_HI   = 5'd7;
    localparam logic [4:0] HDR_COL_END_LO   = 5'd9;
    localparam logic [4:0] HDR_PAD_ROW      = 5'd10;
    localparam logic [4:0] HDR_CMD_ROW      = 5'd11;
    localparam logic [4:0] HDR_ROW_START_HI = 5'd13;
    localparam logic [4:0] HDR_ROW_START_LO = 5'd15;
    localparam logic [4:0] HDR_ROW_END_HI   = 5'd17;
    localparam logic [4:0] HDR_ROW_END_LO   = 5'd19;
    localparam logic [4:0] HDR_PAD_MEM      = 5'd20;
    localparam logic [4:0] HDR_CMD_MEM      = 5'd21;

    typedef enum logic [1:0] {
        ACT_OPEN    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_FILL    = 2'd2,
        ACT_REFRESH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_FILL  = 2'd2,
        ST_EXEC  = 2'd3
    } state_t;

    typedef struct packed {
        logic                   open;
        logic                   write;
        logic [LFB_COORD_W-1:0] pos_x;
        logic [LFB_COORD_W-1:0] pos_y;
        logic [LFB_COORD_W-1:0] rect_width;
        logic [LFB_COORD_W-1:0] rect_height;
    } rect_cmd_t;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       data_select;
    } hdr_t;

    typedef struct packed {
        logic [7:0] hdr_byte;
        logic       data_select;
        logic       in_data;
        logic [1:0] phase;
        logic       frame_end;
    } refresh_info_t;

    // Byte and register-select level of one position in the row header.
    function automatic hdr_t hdr_entry(input logic [4:0]  idx,
                                       input logic [15:0] row,
                                       input logic [15:0] col_end,
                                       input logic [15:0] row_end);
        hdr_t r;
        r.lcd_byte    = 8'h00;
        r.data_select = 1'b1;
        case (idx)
            HDR_PAD_COL, HDR_PAD_ROW, HDR_PAD_MEM: r.data_select = 1'b0;
            HDR_CMD_COL:
            begin
                r.data_select = 1'b0;
                r.lcd_byte    = CMD_COL_ADDR;
            end
            HDR_CMD_ROW:
            begin
                r.data_select = 1'b0;
                r.lcd_byte    = CMD_ROW_ADDR;
            end
            HDR_CMD_MEM:
            begin
                r.data_select = 1'b0;
                r.lcd_byte    = CMD_MEM_WRITE;
            end
            HDR_COL_END_HI:   r.lcd_byte = col_end[15:8];
            HDR_COL_END_LO:   r.lcd_byte = col_end[7:0];
            HDR_ROW_START_HI: r.lcd_byte = row[15:8];
            HDR_ROW_START_LO: r.lcd_byte = row[7:0];
            HDR_ROW_END_HI:   r.lcd_byte = row_end[15:8];
            HDR_ROW_END_LO:   r.lcd_byte = row_end[7:0];
            default:          r.lcd_byte = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/lfb_frame_mem.sv =====
// Single-port-write, single-port-read frame store with a registered read.
module lfb_frame_mem
    import lfb_pkg::*;
#(
    parameter int DEPTH  = LFB_SCREEN_WIDTH * LFB_SCREEN_HEIGHT,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_W-1:0]      waddr,
    input  logic [LFB_PIXEL_W-1:0] wdata,
    input  logic [ADDR_W-1:0]      raddr,
    output logic [LFB_PIXEL_W-1:0] rdata
);

    logic [LFB_PIXEL_W-1:0] store_mem [DEPTH];
    logic [LFB_PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lfb_rect.sv =====
// Rectangle clipping, write cursor and write address generation.
module lfb_rect
    import lfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = LFB_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = LFB_SCREEN_HEIGHT,
    parameter int ADDR_W        = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rect_cmd_t         cmd,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic              truncated
);

    localparam int COL_W = $clog2(SCREEN_WIDTH);
    localparam int ROW_W = $clog2(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0]      W_ADDR  = ADDR_W'(SCREEN_WIDTH);
    localparam logic [LFB_COORD_W-1:0] W_COORD = LFB_COORD_W'(SCREEN_WIDTH);
    localparam logic [LFB_COORD_W-1:0] H_COORD = LFB_COORD_W'(SCREEN_HEIGHT);

    logic [LFB_COORD_W-1:0] width_reg, width_next;
    logic [LFB_COORD_W-1:0] height_reg, height_next;
    logic [LFB_COORD_W-1:0] col_reg, col_next;
    logic [LFB_COORD_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0]      wptr_reg, wptr_next;
    logic                   clip_reg, clip_next;

    logic                   off_screen;
    logic                   write_ok;
    logic [LFB_COORD_W:0]   x_end;
    logic [LFB_COORD_W:0]   y_end;
    logic [LFB_COORD_W-1:0] col_inc;
    logic [ADDR_W-1:0]      origin;

    always_comb
    begin
        off_screen = (cmd.pos_x >= W_COORD) || (cmd.pos_y >= H_COORD);
        x_end      = {1'b0, cmd.pos_x} + {1'b0, cmd.rect_width};
        y_end      = {1'b0, cmd.pos_y} + {1'b0, cmd.rect_height};
        origin     = ADDR_W'(cmd.pos_y[ROW_W-1:0]) * W_ADDR + ADDR_W'(cmd.pos_x[COL_W-1:0]);
        write_ok   = (row_reg < height_reg) && (col_reg < width_reg);
        col_inc    = col_reg + 1'b1;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        wptr_next   = wptr_reg;
        clip_next   = clip_reg;
        if (cmd.open)
        begin
            col_next = '0;
            row_next = '0;
            if (off_screen)
            begin
                clip_next   = 1'b1;
                width_next  = '0;
                height_next = '0;
                wptr_next   = '0;
            end
            else
            begin
                clip_next   = 1'b0;
                wptr_next   = origin;
                width_next  = cmd.rect_width;
                height_next = cmd.rect_height;
                if (y_end > {1'b0, H_COORD})
                begin
                    height_next = H_COORD - cmd.pos_y;
                    clip_next   = 1'b1;
                end
                if (x_end > {1'b0, W_COORD})
                begin
                    width_next = W_COORD - cmd.pos_x;
                    clip_next  = 1'b1;
                end
            end
        end
        else if (cmd.write && write_ok)
        begin
            if (col_inc >= width_reg)
            begin
                // Jump from the end of this row to the start of the next one.
                col_next  = '0;
                row_next  = row_reg + 1'b1;
                wptr_next = wptr_reg + W_ADDR - ADDR_W'(width_reg) + 1'b1;
            end
            else
            begin
                col_next  = col_inc;
                wptr_next = wptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            wptr_reg   <= '0;
            clip_reg   <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            wptr_reg   <= wptr_next;
            clip_reg   <= clip_next;
        end
    end

    assign wr_en     = cmd.write && write_ok;
    assign wr_addr   = wptr_reg;
    assign truncated = clip_reg;

endmodule

// ===== rtl/lfb_refresh.sv =====
// Refresh stream position: row header bytes, pixel byte phase and read pointer.
module lfb_refresh
    import lfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = LFB_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = LFB_SCREEN_HEIGHT,
    parameter int ADDR_W        = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    output refresh_info_t     info,
    output logic [ADDR_W-1:0] rd_addr
);

    localparam int ROW_BYTES = LFB_ROW_HEAD + 3 * SCREEN_WIDTH;
    localparam int IDX_W     = $clog2(ROW_BYTES);
    localparam int ROW_W     = $clog2(SCREEN_HEIGHT);

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [1:0]        phase_reg, phase_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;

    logic in_data;
    logic row_end;
    logic frame_end;
    hdr_t hdr;

    always_comb
    begin
        in_data   = idx_reg >= IDX_W'(LFB_ROW_HEAD);
        row_end   = idx_reg == IDX_W'(ROW_BYTES - 1);
        frame_end = row_end && (row_reg == ROW_W'(SCREEN_HEIGHT - 1));
        hdr       = hdr_entry(idx_reg[4:0], 16'(row_reg), 16'(SCREEN_WIDTH - 1),
                              16'(SCREEN_HEIGHT - 1));
    end

    always_comb
    begin
        idx_next   = idx_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        if (advance)
        begin
            idx_next = row_end ? '0 : idx_reg + 1'b1;
            if (row_end)
            begin
                row_next = frame_end ? '0 : row_reg + 1'b1;
            end
            if (in_data)
            begin
                if (phase_reg == 2'd2)
                begin
                    phase_next = 2'd0;
                    ptr_next   = frame_end ? '0 : ptr_reg + 1'b1;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= 2'd0;
            ptr_reg   <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_comb
    begin
        info.hdr_byte    = hdr.lcd_byte;
        info.data_select = in_data ? 1'b1 : hdr.data_select;
        info.in_data     = in_data;
        info.phase       = phase_reg;
        info.frame_end   = frame_end;
    end

    assign rd_addr = ptr_reg;

endmodule

// ===== rtl/lcd_framebuffer_blit_and_refresh_core.sv =====
// Top level of the framebuffer blit and refresh core for a serial LCD.
//
// The slave stream carries commands: tuser selects the action (open a clipped
// rectangle, write one RGBA pixel into it, fill the whole frame with one color,
// or fetch the next byte of the refresh stream). Every accepted transaction
// produces exactly one master transaction holding the refresh byte, its
// register-select level, a byte-valid flag, the end-of-frame mark on tlast and
// the truncated status of the current rectangle.
//
// Open, write and refresh transactions pass through the EXEC state: the command
// is accepted, the frame store is written or read (a registered read on its
// single read port), and the result is registered from the EXEC state that
// follows acceptance. A fill sweeps the store one pixel per cycle in the FILL
// state and then passes through EXEC as well.
//
// After reset the same sweep clears the store to zero, and tready stays low
// until the clear is done.
// When the receiver stalls, the result stays in the output register and no
// new command is accepted until that result is taken.
module lcd_framebuffer_blit_and_refresh_core
    import lfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = LFB_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = LFB_SCREEN_HEIGHT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // From bit 0: pos_x, pos_y, rect_width, rect_height, pixel_rgba,
    // fill_red, fill_green, fill_blue.
    input  logic [LFB_IN_TDATA_W-1:0]  s_axis_tdata,
    // From bit 0: action.
    input  logic [1:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // From bit 0: lcd_byte, truncated, zero padding.
    output logic [LFB_OUT_TDATA_W-1:0] m_axis_tdata,
    // From bit 0: data_select, byte_valid.
    output logic [1:0]                 m_axis_tuser,
    // frame_last.
    output logic                       m_axis_tlast
);

    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(PIXELS);

    // Unpacked command fields.
    action_t                action;
    logic [LFB_COORD_W-1:0] pos_x;
    logic [LFB_COORD_W-1:0] pos_y;
    logic [LFB_COORD_W-1:0] rect_width;
    logic [LFB_COORD_W-1:0] rect_height;
    logic [31:0]            pixel_rgba;
    logic [7:0]             fill_red;
    logic [7:0]             fill_green;
    logic [7:0]             fill_blue;

    assign action      = action_t'(s_axis_tuser);
    assign pos_x       = s_axis_tdata[11:0];
    assign pos_y       = s_axis_tdata[23:12];
    assign rect_width  = s_axis_tdata[35:24];
    assign rect_height = s_axis_tdata[47:36];
    assign pixel_rgba  = s_axis_tdata[79:48];
    assign fill_red    = s_axis_tdata[87:80];
    assign fill_green  = s_axis_tdata[95:88];
    assign fill_blue   = s_axis_tdata[103:96];

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      sweep_addr_reg, sweep_addr_next;
    logic [LFB_PIXEL_W-1:0] fill_color_reg, fill_color_next;
    action_t                pend_action_reg;
    refresh_info_t          pend_info_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_byte_reg, m_byte_next;
    logic                   m_sel_reg, m_sel_next;
    logic                   m_bvalid_reg, m_bvalid_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_trunc_reg, m_trunc_next;

    logic                   accept;
    logic                   sweeping;
    logic                   sweep_end;
    rect_cmd_t              rect_cmd;
    logic                   rect_we;
    logic [ADDR_W-1:0]      rect_addr;
    logic                   truncated;
    refresh_info_t          refresh_info;
    logic                   refresh_advance;
    logic [ADDR_W-1:0]      rd_addr;
    logic [LFB_PIXEL_W-1:0] rd_data;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [LFB_PIXEL_W-1:0] mem_wdata;
    logic [7:0]             pixel_byte;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign sweep_end = sweep_addr_reg == ADDR_W'(PIXELS - 1);

    always_comb
    begin
        rect_cmd.open        = accept && (action == ACT_OPEN);
        rect_cmd.write       = accept && (action == ACT_WRITE);
        rect_cmd.pos_x       = pos_x;
        rect_cmd.pos_y       = pos_y;
        rect_cmd.rect_width  = rect_width;
        rect_cmd.rect_height = rect_height;
    end

    assign refresh_advance = accept && (action == ACT_REFRESH);

    lfb_rect #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ADDR_W        (ADDR_W)
    ) u_rect (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (rect_cmd),
        .wr_en     (rect_we),
        .wr_addr   (rect_addr),
        .truncated (truncated)
    );

    lfb_refresh #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ADDR_W        (ADDR_W)
    ) u_refresh (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (refresh_advance),
        .info    (refresh_info),
        .rd_addr (rd_addr)
    );

    // The read port samples the refresh pointer on every edge; the byte for a
    // refresh transaction is therefore ready in the cycle after it is accepted.
    lfb_frame_mem #(
        .DEPTH  (PIXELS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action == ACT_FILL) ? ST_FILL : ST_EXEC;
                end
            end
            ST_FILL:
            begin
                if (sweep_end)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, sweep enable and the store's write port.
    always_comb
    begin
        s_axis_tready = 1'b0;
        sweeping      = 1'b0;
        case (state_reg)
            ST_CLEAR: sweeping = 1'b1;
            ST_FILL:  sweeping = 1'b1;
            ST_IDLE:  s_axis_tready = !m_valid_reg || m_axis_tready;
            default:  sweeping = 1'b0;
        endcase
        if (sweeping)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = fill_color_reg;
        end
        else
        begin
            // Pixel bytes are stored first, second, third = byte 2, 1, 0; alpha drops.
            mem_we    = rect_we;
            mem_waddr = rect_addr;
            mem_wdata = pixel_rgba[23:0];
        end
    end

    always_comb
    begin
        sweep_addr_next = sweep_addr_reg;
        fill_color_next = fill_color_reg;
        if (sweeping)
        begin
            sweep_addr_next = sweep_end ? '0 : sweep_addr_reg + 1'b1;
        end
        if (accept && (action == ACT_FILL))
        begin
            fill_color_next = {fill_red, fill_green, fill_blue};
        end
    end

    always_comb
    begin
        case (pend_info_reg.phase)
            2'd0:    pixel_byte = rd_data[23:16];
            2'd1:    pixel_byte = rd_data[15:8];
            default: pixel_byte = rd_data[7:0];
        endcase
    end

    // Output register: loaded once per command, held while the receiver stalls.
    always_comb
    begin
        m_valid_next  = m_valid_reg;
        m_byte_next   = m_byte_reg;
        m_sel_next    = m_sel_reg;
        m_bvalid_next = m_bvalid_reg;
        m_last_next   = m_last_reg;
        m_trunc_next  = m_trunc_reg;
        if (state_reg == ST_EXEC)
        begin
            m_valid_next = 1'b1;
            m_trunc_next = truncated;
            if (pend_action_reg == ACT_REFRESH)
            begin
                m_byte_next   = pend_info_reg.in_data ? pixel_byte : pend_info_reg.hdr_byte;
                m_sel_next    = pend_info_reg.data_select;
                m_bvalid_next = 1'b1;
                m_last_next   = pend_info_reg.frame_end;
            end
            else
            begin
                m_byte_next   = 8'h00;
                m_sel_next    = 1'b0;
                m_bvalid_next = 1'b0;
                m_last_next   = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_addr_reg <= '0;
            fill_color_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            fill_color_reg <= fill_color_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_action_reg <= action;
            pend_info_reg   <= refresh_info;
        end
        m_byte_reg   <= m_byte_next;
        m_sel_reg    <= m_sel_next;
        m_bvalid_reg <= m_bvalid_next;
        m_last_reg   <= m_last_next;
        m_trunc_reg  <= m_trunc_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(LFB_OUT_TDATA_W - 9)'(0), m_trunc_reg, m_byte_reg};
    assign m_axis_tuser  = {m_bvalid_reg, m_sel_reg};
    assign m_axis_tlast  = m_last_reg;

`include "assert_macros.svh"

    `CHK_NEXT(a_accept_starts_work, accept,
              (state_reg == ST_EXEC) || (state_reg == ST_FILL),
              "accepted command did not start execution")
    `CHK_IMPL(a_result_from_exec, $rose(m_axis_tvalid),
              $past(state_reg == ST_EXEC),
              "result appeared without an executed command")
    `CHK_IMPL(a_last_is_refresh, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1],
              "frame end marked on a non-refresh result")

endmodule
